>>> rtl/rrss_pkg.sv
// Shared types and constants of the round-robin slice scheduler.
`default_nettype none

package rrss_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int CMD_W    = 2;
  localparam int TIME_BITS = 16;
  localparam int QUANT_W  = 16;
  localparam int JOBN_W   = 7;
  localparam int CLOCK_W  = 22;
  localparam int SUM_W    = 28;

  // Quantum after reset.
  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(4);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // One input item.
  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [TIME_BITS-1:0] burst_time;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [JOBN_W-1:0]  job_number;
    logic [CLOCK_W-1:0] slice_start;
    logic [CLOCK_W-1:0] slice_end;
    logic               job_finished;
    logic [CLOCK_W-1:0] wait_time;
    logic [CLOCK_W-1:0] turnaround_time;
    logic [SUM_W-1:0]   total_wait;
    logic [SUM_W-1:0]   total_turnaround;
    logic               all_done;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan_run;
    logic calc;
    logic wt_calc;
    logic emit_slice;
    logic emit_done;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic miss;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/rrss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rrss_ctrl.sv
// Controller state machine of the round-robin slice scheduler.
`default_nettype none

module rrss_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [rrss_pkg::CMD_W-1:0] command,
  input  wire rrss_pkg::sts_t           sts,
  output rrss_pkg::ctl_t                ctl,
  output logic                          busy,
  output logic                          result_valid
);

  import rrss_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_CALC = 5'b00100,
    ST_WTC  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_LOAD: begin
              ctl.load = 1'b1;
            end
            CMD_STEP: begin
              ctl.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctl.scan_run = 1'b1;
        priority if (sts.hit) begin
          state_next = ST_CALC;
        end else if (sts.miss) begin
          ctl.emit_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_CALC: begin
        ctl.calc   = 1'b1;
        state_next = ST_WTC;
      end
      ST_WTC: begin
        ctl.wt_calc = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.emit_slice = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and the one-cycle result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= ctl.emit_slice || ctl.emit_done;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/rrss_dp.sv
// Datapath of the round-robin slice scheduler: job tables, scan and time arithmetic.
`default_nettype none

module rrss_dp #(
  parameter int MAX_JOBS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rrss_pkg::TIME_BITS-1:0] burst_time,
  input  wire rrss_pkg::ctl_t                ctl,
  output rrss_pkg::sts_t                     sts,
  input  wire logic                          cfg_we,
  input  wire logic [rrss_pkg::QUANT_W-1:0]  cfg_data,
  output rrss_pkg::result_t                  result
);

  import rrss_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // Architectural state.
  logic [QUANT_W-1:0] quantum;
  logic [CNT_W-1:0]   job_count;
  logic [IDX_W-1:0]   scan_pos;
  logic [CLOCK_W-1:0] cur_time;
  logic [SUM_W-1:0]   wait_sum;
  logic [SUM_W-1:0]   tat_sum;

  // Scan pipeline.
  logic [IDX_W-1:0]   issue_idx;
  logic [CNT_W-1:0]   issue_cnt;
  logic [IDX_W-1:0]   chk_idx;
  logic [CNT_W-1:0]   chk_cnt;
  logic               chk_valid;

  // Served job and slice arithmetic.
  logic [IDX_W-1:0]     slot;
  logic [TIME_BITS-1:0] rem_r;
  logic [TIME_BITS-1:0] burst_r;
  logic                 done_r;
  logic [CLOCK_W-1:0]   start_r;
  logic [CLOCK_W-1:0]   wt_r;

  // Table ports.
  logic [TIME_BITS-1:0] rem_rdata;
  logic [TIME_BITS-1:0] burst_rdata;
  logic                 rem_we;
  logic [IDX_W-1:0]     rem_waddr;
  logic [TIME_BITS-1:0] rem_wdata;
  logic                 burst_we;

  // Combinational helpers.
  logic                 table_full;
  logic [IDX_W-1:0]     scan_first;
  logic                 issue_more;
  logic [IDX_W-1:0]     issue_next;
  logic                 chk_last;
  logic                 done_c;
  logic [TIME_BITS-1:0] len_c;
  logic [CLOCK_W-1:0]   new_time;
  logic [TIME_BITS-1:0] rem_left;
  logic [IDX_W-1:0]     slot_next;
  logic [SUM_W-1:0]     wait_sum_next;
  logic [SUM_W-1:0]     tat_sum_next;

  assign table_full = (job_count == CNT_W'(MAX_JOBS));

  // The scan starts after the last served job, or at entry zero when that is past the end.
  assign scan_first = (CNT_W'(scan_pos) >= job_count) ? '0 : scan_pos;

  // Cyclic read address walk over the loaded entries.
  assign issue_more = (issue_cnt != job_count);
  assign issue_next = ((CNT_W'(issue_idx) + CNT_W'(1)) == job_count) ?
                      '0 : issue_idx + IDX_W'(1);
  assign chk_last   = ((chk_cnt + CNT_W'(1)) == job_count);

  assign sts.hit  = chk_valid && (rem_rdata != '0);
  assign sts.miss = (job_count == '0) || (chk_valid && (rem_rdata == '0) && chk_last);

  // Slice length and the new clock.
  assign done_c   = (rem_r <= quantum);
  assign len_c    = done_c ? rem_r : quantum;
  assign new_time = cur_time + CLOCK_W'(len_c);
  assign rem_left = rem_r - quantum;
  assign slot_next = ((CNT_W'(slot) + CNT_W'(1)) == job_count) ? '0 : slot + IDX_W'(1);

  // Sums including the job that finishes in this slice.
  assign wait_sum_next = done_r ? wait_sum + SUM_W'(wt_r) : wait_sum;
  assign tat_sum_next  = done_r ? tat_sum + SUM_W'(cur_time) : tat_sum;

  // Table writes: a load appends, a slice updates the remaining time.
  assign burst_we  = ctl.load && !table_full;
  assign rem_we    = burst_we || ctl.calc;
  assign rem_waddr = ctl.load ? job_count[IDX_W-1:0] : slot;
  assign rem_wdata = ctl.load ? burst_time : (done_c ? '0 : rem_left);

  rrss_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_JOBS)
  ) u_burst_ram (
    .clk   (clk),
    .we    (burst_we),
    .waddr (job_count[IDX_W-1:0]),
    .wdata (burst_time),
    .raddr (issue_idx),
    .rdata (burst_rdata)
  );

  rrss_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_JOBS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (issue_idx),
    .rdata (rem_rdata)
  );

  // Schedule state, counters and sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum   <= QUANT_RESET;
      job_count <= '0;
      scan_pos  <= '0;
      cur_time  <= '0;
      wait_sum  <= '0;
      tat_sum   <= '0;
      issue_cnt <= '0;
      chk_cnt   <= '0;
      chk_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_data;
      end
      if (burst_we) begin
        job_count <= job_count + CNT_W'(1);
      end
      if (ctl.clear) begin
        job_count <= '0;
        scan_pos  <= '0;
        cur_time  <= '0;
        wait_sum  <= '0;
        tat_sum   <= '0;
      end
      if (ctl.scan_start) begin
        issue_cnt <= '0;
        chk_cnt   <= '0;
        chk_valid <= 1'b0;
      end
      if (ctl.scan_run) begin
        chk_valid <= issue_more;
        if (issue_more) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
        if (chk_valid) begin
          chk_cnt <= chk_cnt + CNT_W'(1);
        end
      end
      if (ctl.calc) begin
        cur_time <= new_time;
        scan_pos <= slot_next;
      end
      if (ctl.emit_slice) begin
        wait_sum <= wait_sum_next;
        tat_sum  <= tat_sum_next;
      end
    end
  end

  // Scan addresses, the served job and the result register.
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      issue_idx <= scan_first;
    end
    if (ctl.scan_run) begin
      if (issue_more) begin
        issue_idx <= issue_next;
        chk_idx   <= issue_idx;
      end
      if (sts.hit) begin
        slot    <= chk_idx;
        rem_r   <= rem_rdata;
        burst_r <= burst_rdata;
      end
    end
    if (ctl.calc) begin
      done_r  <= done_c;
      start_r <= cur_time;
    end
    if (ctl.wt_calc) begin
      wt_r <= cur_time - CLOCK_W'(burst_r);
    end
    if (ctl.emit_slice) begin
      result.job_number       <= JOBN_W'({1'b0, slot} + (IDX_W + 1)'(1));
      result.slice_start      <= start_r;
      result.slice_end        <= cur_time;
      result.job_finished     <= done_r;
      result.wait_time        <= done_r ? wt_r : '0;
      result.turnaround_time  <= done_r ? cur_time : '0;
      result.total_wait       <= wait_sum_next;
      result.total_turnaround <= tat_sum_next;
      result.all_done         <= 1'b0;
    end
    if (ctl.emit_done) begin
      result.job_number       <= '0;
      result.slice_start      <= '0;
      result.slice_end        <= '0;
      result.job_finished     <= 1'b0;
      result.wait_time        <= '0;
      result.turnaround_time  <= '0;
      result.total_wait       <= wait_sum;
      result.total_turnaround <= tat_sum;
      result.all_done         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/round_robin_slice_scheduler.sv
// Top level of the round-robin slice scheduler.
//
// Usage: an item (command, burst_time) transfers at a rising edge with start high
// and busy low. A load appends a job and a clear empties the table; both finish in
// the accepting cycle and give no result, so they can follow back to back.
// A step scans the job table for the next job with work left and gives exactly one
// result on the result port, marked by result_valid for one cycle. The receiver
// cannot hold results off.
// A step keeps busy high until the edge that loads the result register, so the next
// item can transfer at the edge that ends the result cycle. The scan reads one table
// entry per cycle through the registered read port of the remaining-time RAM.
// The quantum is written through cfg_valid/cfg_ready/cfg_data, always ready; the
// user must write it only while the block is idle, which the block itself does not
// enforce. Synchronous reset sets the quantum to 4, empties the table and zeroes
// the clock and sums; table contents are not cleared.
`default_nettype none

module round_robin_slice_scheduler #(
  parameter int MAX_JOBS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rrss_pkg::item_t             item,
  output logic                             result_valid,
  output rrss_pkg::result_t                result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rrss_pkg::QUANT_W-1:0] cfg_data
);

  import rrss_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The quantum register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  rrss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (item.command),
    .sts          (sts),
    .ctl          (ctl),
    .busy         (busy),
    .result_valid (result_valid)
  );

  rrss_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .burst_time (item.burst_time),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .result     (result)
  );

endmodule

`default_nettype wire

>>> rtl/rrss_checker.sv
// Port-level assertions of the round-robin slice scheduler and their binding.
`default_nettype none

module rrss_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              busy,
  input wire logic              result_valid,
  input wire rrss_pkg::result_t result
);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

  // Each step gives one result, so strobes never come in adjacent cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // An all-done result carries no slice.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.all_done) |->
      (result.job_number == '0 && result.slice_start == '0 &&
       result.slice_end == '0 && !result.job_finished))
    else $error("all-done result carries slice fields");

  // A finishing slice reports its end as the job's turnaround time.
  a_finish_tat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.job_finished) |->
      (result.turnaround_time == result.slice_end))
    else $error("turnaround does not match slice end");

  // An unfinished slice reports no per-job times.
  a_unfinished_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.all_done && !result.job_finished) |->
      (result.wait_time == '0 && result.turnaround_time == '0))
    else $error("unfinished slice carries job times");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the round-robin slice scheduler.
`timescale 1ns / 1ps

module tb;
  import rrss_pkg::*;

  localparam int JOB_SLOTS = 64;

  // Keeps its own copy of the job table, predicts each slice and matches the results.
  class slice_tracker;
    logic [TIME_BITS-1:0] burst_tbl  [JOB_SLOTS];
    logic [TIME_BITS-1:0] remain_tbl [JOB_SLOTS];
    int unsigned          job_cnt;
    int unsigned          scan_pos;
    logic [CLOCK_W-1:0]   now_time;
    logic [SUM_W-1:0]     wait_total;
    logic [SUM_W-1:0]     tat_total;
    logic [QUANT_W-1:0]   quantum;
    result_t              due_slices[$];
    int                   slips;
    int                   faults;

    function new();
      empty_table();
      quantum = QUANT_RESET;
      slips = 0;
      faults = 0;
    endfunction

    function void empty_table();
      job_cnt = 0;
      scan_pos = 0;
      now_time = '0;
      wait_total = '0;
      tat_total = '0;
    endfunction

    function void set_quantum(logic [QUANT_W-1:0] q);
      quantum = q;
    endfunction

    function int pending();
      return due_slices.size();
    endfunction

    function int jobs();
      return job_cnt;
    endfunction

    // True while some loaded job still has time left to run.
    function bit work_left();
      bit any;
      any = 1'b0;
      for (int unsigned i = 0; i < job_cnt; i++) begin
        if (remain_tbl[i] != '0) any = 1'b1;
      end
      return any;
    endfunction

    // Notes one accepted input transfer; returns 1 when the block acts on it.
    function bit note_item(item_t it);
      int unsigned        idx;
      int unsigned        slot;
      bit                 found;
      bit                 done;
      logic [QUANT_W-1:0] rem;
      logic [QUANT_W-1:0] len;
      logic [CLOCK_W-1:0] wt;
      result_t            res;
      case (it.command)
        CMD_LOAD: begin
          // A load into a full table is dropped.
          if (job_cnt >= JOB_SLOTS) return 1'b0;
          burst_tbl[job_cnt] = it.burst_time;
          remain_tbl[job_cnt] = it.burst_time;
          job_cnt++;
          return 1'b1;
        end
        CMD_CLEAR: begin
          empty_table();
          return 1'b1;
        end
        CMD_STEP: begin
          res = '0;
          if (scan_pos >= job_cnt) scan_pos = 0;
          found = 1'b0;
          slot = 0;
          // Look for the next job with work left, starting after the last one served.
          for (int unsigned k = 0; k < job_cnt; k++) begin
            idx = scan_pos + k;
            if (idx >= job_cnt) idx -= job_cnt;
            if (!found && remain_tbl[idx] != '0) begin
              slot = idx;
              found = 1'b1;
            end
          end
          if (!found) begin
            res.all_done = 1'b1;
          end else begin
            rem = remain_tbl[slot];
            done = (rem <= quantum);
            len = done ? rem : quantum;
            res.job_number = JOBN_W'(slot + 1);
            res.slice_start = now_time;
            now_time = now_time + CLOCK_W'(len);
            res.slice_end = now_time;
            if (done) begin
              wt = now_time - CLOCK_W'(burst_tbl[slot]);
              remain_tbl[slot] = '0;
              wait_total = wait_total + SUM_W'(wt);
              tat_total = tat_total + SUM_W'(now_time);
              res.job_finished = 1'b1;
              res.wait_time = wt;
              res.turnaround_time = now_time;
            end else begin
              remain_tbl[slot] = rem - quantum;
            end
            scan_pos = slot + 1;
            if (scan_pos >= job_cnt) scan_pos = 0;
          end
          res.total_wait = wait_total;
          res.total_turnaround = tat_total;
          due_slices.push_back(res);
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf({"job=%0d start=%0d end=%0d fin=%0b wait=%0d tat=%0d ",
                        "sum_wait=%0d sum_tat=%0d all_done=%0b"},
                       r.job_number, r.slice_start, r.slice_end, r.job_finished,
                       r.wait_time, r.turnaround_time, r.total_wait,
                       r.total_turnaround, r.all_done);
    endfunction

    // Matches one result transfer against the oldest predicted slice.
    function void check_slice(result_t got);
      result_t want;
      if (due_slices.size() == 0) begin
        faults++;
        slips++;
        if (slips <= 10) $display("unexpected slice: %s", show(got));
        return;
      end
      want = due_slices.pop_front();
      if (got !== want) begin
        faults++;
        slips++;
        if (slips <= 10) begin
          $display("slice mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    endfunction

    // Predicted slices still waiting at the end are failures.
    function void close_out();
      if (due_slices.size() != 0) begin
        faults += due_slices.size();
        $display("%0d predicted slices never arrived", due_slices.size());
      end
    endfunction
  endclass

  localparam int          ITEM_GOAL     = 1100;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 72;
  localparam logic [1:0]  CMD_NONE      = 2'd3;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  item_t              item = '0;
  logic               cfg_valid = 1'b0;
  logic [QUANT_W-1:0] cfg_data = '0;
  logic               busy;
  logic               result_valid;
  result_t            result;
  logic               cfg_ready;

  slice_tracker ledger;
  int           items_done;
  int           cycles;
  bit           calm;

  round_robin_slice_scheduler #(
    .MAX_JOBS(JOB_SLOTS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial ledger = new();

  // Every result transfer is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) ledger.check_slice(result);
  end

  // Hard stop in case the block hangs.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[round_robin_slice_scheduler] ERROR");
      $finish;
    end
  end

  // Random gap after a transfer: mostly none or short, now and then long.
  task automatic pace();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one item and waits for its transfer; start stays high if no gap follows.
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [TIME_BITS-1:0] burst);
    item_t it;
    it.command = cmd;
    it.burst_time = burst;
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (ledger.note_item(it)) items_done++;
    pace();
  endtask

  // Waits until every predicted slice has come and the block has had time to finish.
  task automatic settle();
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [QUANT_W-1:0] q);
    settle();
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= q;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_quantum(q);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [QUANT_W-1:0] pick_quantum();
    case ($urandom_range(0, 9))
      0: return QUANT_W'(1);
      1: return QUANT_W'(65535);
      2: return QUANT_W'(0);
      3, 4, 5, 6: return QUANT_W'($urandom_range(1, 16));
      default: return QUANT_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // Bursts are mostly a few quanta long so that jobs finish; some span the full range.
  function automatic logic [TIME_BITS-1:0] pick_burst();
    int top;
    if ($urandom_range(0, 9) == 0) return TIME_BITS'($urandom());
    top = 3 * int'(ledger.quantum);
    if (top == 0) top = 8;
    if (top > 65535) top = 65535;
    return TIME_BITS'($urandom_range(0, top));
  endfunction

  initial begin
    int njobs;
    int step_cap;
    int nsteps;
    int r;
    bit stop;
    items_done = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, ignored command, zero burst, exact quantum, late load.
    push_item(CMD_STEP, 16'h0000);
    push_item(CMD_NONE, 16'hFFFF);
    push_item(CMD_LOAD, 16'd0);
    push_item(CMD_LOAD, 16'd1);
    push_item(CMD_LOAD, 16'd4);
    push_item(CMD_LOAD, 16'd5);
    push_item(CMD_LOAD, 16'd3);
    repeat (6) push_item(CMD_STEP, 16'hFFFF);
    push_item(CMD_LOAD, 16'd2);
    repeat (2) push_item(CMD_STEP, 16'h0000);

    // Directed: largest quantum with the largest bursts.
    write_quantum(16'hFFFF);
    push_item(CMD_CLEAR, 16'hFFFF);
    push_item(CMD_LOAD, 16'hFFFF);
    push_item(CMD_LOAD, 16'hFFFE);
    repeat (3) push_item(CMD_STEP, 16'h0000);

    // Directed: zero quantum gives empty slices and time stands still.
    write_quantum(16'd0);
    push_item(CMD_CLEAR, 16'h0000);
    push_item(CMD_LOAD, 16'd2);
    push_item(CMD_LOAD, 16'd3);
    repeat (3) push_item(CMD_STEP, 16'h0000);
    write_quantum(16'd1);

    // Random episodes: clear, fill the table, then run slices with some noise.
    while (items_done < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) write_quantum(pick_quantum());
      calm = ($urandom_range(0, 4) == 0);
      push_item(CMD_CLEAR, TIME_BITS'($urandom()));
      r = $urandom_range(0, 9);
      if (r < 7) njobs = $urandom_range(1, 8);
      else if (r < 9) njobs = $urandom_range(9, 32);
      else njobs = $urandom_range(60, 68);
      for (int i = 0; i < njobs; i++) push_item(CMD_LOAD, pick_burst());
      step_cap = 4 * ledger.jobs() + 16;
      nsteps = 0;
      stop = 1'b0;
      while (!stop && nsteps < step_cap) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          push_item(CMD_LOAD, pick_burst());
        end else if (r < 6) begin
          push_item(CMD_NONE, TIME_BITS'($urandom()));
        end else if (r < 7) begin
          push_item(CMD_CLEAR, TIME_BITS'($urandom()));
          stop = 1'b1;
        end else begin
          push_item(CMD_STEP, TIME_BITS'($urandom()));
          nsteps++;
          // One more step once everything is done shows the all-done report.
          if (!ledger.work_left()) begin
            push_item(CMD_STEP, TIME_BITS'($urandom()));
            stop = 1'b1;
          end
        end
      end
    end

    settle();
    ledger.close_out();
    if (ledger.faults == 0) begin
      $display("[round_robin_slice_scheduler] OK");
    end else begin
      $display("[round_robin_slice_scheduler] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/rrss_pkg.sv
rtl/rrss_ram.sv
rtl/rrss_ctrl.sv
rtl/rrss_dp.sv
rtl/round_robin_slice_scheduler.sv
rtl/rrss_checker.sv
tb/tb.sv
